>>> hw/rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared constants and types for the point-in-polygon test core.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

   localparam int MAX_VERTICES  = 64;
   localparam int COORD_BITS    = 32;
   localparam int ADDR_BITS     = $clog2(MAX_VERTICES);
   localparam int CNT_BITS      = ADDR_BITS + 1;
   localparam int IDX_BITS      = 6;
   localparam int CFG_BITS      = 7;
   localparam int MIN_POLY_VERTS = 3;
   localparam int PROD_BITS     = 2 * (COORD_BITS + 1);

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic valid;
      logic last;
   } edge_ctl_type;

   typedef struct packed {
      logic done;
      logic in_poly;
   } edge_res_type;

endpackage

`default_nettype wire

>>> hw/rtl/pip_ram.sv
// ----------------------------------------------------------------------------
// pip_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> hw/rtl/pip_edge_unit.sv
// ----------------------------------------------------------------------------
// pip_edge_unit
// Three-stage edge crossing test, one edge per cycle, with parity tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_edge_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 clear,
   input  wire pip_pkg::edge_ctl_type                ctl,
   input  wire logic signed [pip_pkg::COORD_BITS-1:0] px,
   input  wire logic signed [pip_pkg::COORD_BITS-1:0] py,
   input  wire logic signed [pip_pkg::COORD_BITS-1:0] xj,
   input  wire logic signed [pip_pkg::COORD_BITS-1:0] yj,
   input  wire logic signed [pip_pkg::COORD_BITS-1:0] xi,
   input  wire logic signed [pip_pkg::COORD_BITS-1:0] yi,
   output pip_pkg::edge_res_type                     res
);

   localparam int CB = pip_pkg::COORD_BITS;
   localparam int PB = pip_pkg::PROD_BITS;

   // stage 1: differences
   pip_pkg::edge_ctl_type s1_ctl_ff, s1_ctl_in;
   logic                  s1_hit_ff, s1_hit_in;
   logic                  s1_dypos_ff, s1_dypos_in;
   logic signed [CB:0]    dx1_ff, dx1_in;
   logic signed [CB:0]    dy_ff, dy_in;
   logic signed [CB:0]    dx2_ff, dx2_in;
   logic signed [CB:0]    dyp_ff, dyp_in;

   // stage 2: products
   pip_pkg::edge_ctl_type s2_ctl_ff;
   logic                  s2_hit_ff;
   logic                  s2_dypos_ff;
   logic signed [PB-1:0]  lhs_ff, lhs_in;
   logic signed [PB-1:0]  rhs_ff, rhs_in;

   // stage 3: parity
   logic parity_ff, parity_in;
   logic done_ff, done_in;
   logic in_poly_ff, in_poly_in;
   logic left;
   logic toggle;

   always_comb begin
      s1_ctl_in   = ctl;
      s1_hit_in   = (yi > py) != (yj > py);
      dx1_in      = {px[CB-1], px} - {xi[CB-1], xi};
      dy_in       = {yj[CB-1], yj} - {yi[CB-1], yi};
      dx2_in      = {xj[CB-1], xj} - {xi[CB-1], xi};
      dyp_in      = {py[CB-1], py} - {yi[CB-1], yi};
      s1_dypos_in = yj > yi;
   end

   always_comb begin
      lhs_in = dx1_ff * dy_ff;
      rhs_in = dx2_ff * dyp_ff;
   end

   always_comb begin
      left       = s2_dypos_ff ? (lhs_ff < rhs_ff) : (rhs_ff < lhs_ff);
      toggle     = s2_ctl_ff.valid && s2_hit_ff && left;
      parity_in  = parity_ff ^ toggle;
      done_in    = s2_ctl_ff.valid && s2_ctl_ff.last;
      in_poly_in = parity_in;
      if (clear) begin
         parity_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         parity_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s1_ctl_ff;
         parity_ff <= parity_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_hit_ff   <= s1_hit_in;
      s1_dypos_ff <= s1_dypos_in;
      dx1_ff      <= dx1_in;
      dy_ff       <= dy_in;
      dx2_ff      <= dx2_in;
      dyp_ff      <= dyp_in;
      s2_hit_ff   <= s1_hit_ff;
      s2_dypos_ff <= s1_dypos_ff;
      lhs_ff      <= lhs_in;
      rhs_ff      <= rhs_in;
      in_poly_ff  <= in_poly_in;
   end

   assign res.done    = done_ff;
   assign res.in_poly = in_poly_ff;

endmodule

`default_nettype wire

>>> hw/rtl/point_in_polygon_test_core.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_core
// Ray-casting point-in-polygon test over a stored vertex list.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with req_* valid while busy is low to hand over one item.
//   A write item (req_kind = 0) stores (req_coord_x, req_coord_y) in slot
//   req_vertex_index and returns nothing; slots past the store are dropped.
//   A query item (req_kind = 1) returns one rsp_inside_res, marked by a
//   one-cycle rsp_valid strobe.
//   csr_wr_en / csr_wr_data set the vertex count (saturated to the store
//   depth); write it only while the block is idle.
//   A query with fewer than three vertices answers in the cycle after
//   acceptance. Otherwise the edge walk reads one vertex per cycle from the
//   vertex RAM; busy stays high through the walk, and the next item is
//   taken only after the result appears.
//   Reset clears the vertex count and the sequencer; vertex slots hold
//   whatever was last written. The receiver cannot stall rsp_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_test_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic                                 req_kind,
   input  wire logic [pip_pkg::IDX_BITS-1:0]          req_vertex_index,
   input  wire logic signed [pip_pkg::COORD_BITS-1:0] req_coord_x,
   input  wire logic signed [pip_pkg::COORD_BITS-1:0] req_coord_y,
   output logic                                      rsp_valid,
   output logic                                      rsp_inside_res,
   input  wire logic                                 csr_wr_en,
   input  wire logic [pip_pkg::CFG_BITS-1:0]          csr_wr_data
);

   localparam int CB = pip_pkg::COORD_BITS;
   localparam int AB = pip_pkg::ADDR_BITS;
   localparam int NB = pip_pkg::CNT_BITS;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [NB-1:0]        vcount_ff, vcount_in;
   logic [NB-1:0]        rd_cnt_ff, rd_cnt_in;
   logic                 rd_vld_ff, rd_first_ff, rd_last_ff;
   logic                 small_ff, small_in;
   logic signed [CB-1:0] px_ff, py_ff;
   logic [2*CB-1:0]      prev_ff;
   logic [2*CB-1:0]      rd_data;
   logic [AB-1:0]        rd_addr;
   logic [AB-1:0]        wr_addr;
   logic                 wr_en;
   logic                 accept;
   logic                 query_go;

   pip_pkg::edge_ctl_type edge_ctl;
   pip_pkg::edge_res_type edge_res;

   assign accept   = start && !busy;
   assign busy     = state_ff != ST_IDLE;
   assign wr_en    = accept && (req_kind == pip_pkg::KIND_WRITE)
                     && (32'(req_vertex_index) < pip_pkg::MAX_VERTICES);
   assign wr_addr  = AB'(req_vertex_index);
   assign query_go = accept && (req_kind == pip_pkg::KIND_QUERY);
   assign small_in = query_go && (vcount_ff < NB'(pip_pkg::MIN_POLY_VERTS));

   always_comb begin
      vcount_in = vcount_ff;
      if (csr_wr_en) begin
         if (32'(csr_wr_data) > pip_pkg::MAX_VERTICES) begin
            vcount_in = NB'(pip_pkg::MAX_VERTICES);
         end else begin
            vcount_in = NB'(csr_wr_data);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      rd_cnt_in = rd_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rd_cnt_in = '0;
            if (query_go && !small_in) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            rd_cnt_in = rd_cnt_ff + 1'b1;
            if (rd_cnt_ff == vcount_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (edge_res.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // walk vertex n-1 first, then 0 .. n-1
   always_comb begin
      if (rd_cnt_ff == '0) begin
         rd_addr = AB'(vcount_ff - 1'b1);
      end else begin
         rd_addr = AB'(rd_cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         vcount_ff <= '0;
         rd_cnt_ff <= '0;
         rd_vld_ff <= 1'b0;
         small_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         vcount_ff <= vcount_in;
         rd_cnt_ff <= rd_cnt_in;
         rd_vld_ff <= state_ff == ST_WALK;
         small_ff  <= small_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_first_ff <= rd_cnt_ff == '0;
      rd_last_ff  <= rd_cnt_ff == vcount_ff;
      if (query_go) begin
         px_ff <= req_coord_x;
         py_ff <= req_coord_y;
      end
      if (rd_vld_ff) begin
         prev_ff <= rd_data;
      end
   end

   pip_ram #(
      .WIDTH(2 * CB),
      .DEPTH(pip_pkg::MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_coord_y, req_coord_x}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign edge_ctl.valid = rd_vld_ff && !rd_first_ff;
   assign edge_ctl.last  = rd_last_ff;

   pip_edge_unit u_edge (
      .clock (clock),
      .reset (reset),
      .clear (query_go),
      .ctl   (edge_ctl),
      .px    (px_ff),
      .py    (py_ff),
      .xj    (prev_ff[CB-1:0]),
      .yj    (prev_ff[2*CB-1:CB]),
      .xi    (rd_data[CB-1:0]),
      .yi    (rd_data[2*CB-1:CB]),
      .res   (edge_res)
   );

   assign rsp_valid      = small_ff || edge_res.done;
   assign rsp_inside_res = small_ff || edge_res.in_poly;

`ifndef SYNTHESIS
   a_no_rsp_in_walk : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff != ST_WALK))
      else $error("result strobe during edge walk");

   a_done_in_drain : assert property (@(posedge clock) disable iff (reset)
      edge_res.done |-> (state_ff == ST_DRAIN))
      else $error("edge unit finished outside drain");

   a_small_inside : assert property (@(posedge clock) disable iff (reset)
      (query_go && (vcount_ff < NB'(pip_pkg::MIN_POLY_VERTS)))
      |=> (rsp_valid && rsp_inside_res))
      else $error("degenerate polygon query not answered inside");

   a_write_silent : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_kind == pip_pkg::KIND_WRITE)) |=> !rsp_valid)
      else $error("write item produced a result");
`endif

endmodule

`default_nettype wire

>>> test/point_in_polygon_test_core_checker.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_core_checker
// Watches the item, result and register ports of the point-in-polygon core.
// Keeps its own vertex store and vertex count, computes the ray-casting parity
// for every accepted query with full-width products, and compares each result
// strobe against the oldest pending answer. Hands the mismatch count and the
// number of answers still due to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module point_in_polygon_test_core_checker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic                                  busy,
   input  wire logic                                  req_kind,
   input  wire logic [pip_pkg::IDX_BITS-1:0]          req_vertex_index,
   input  wire logic signed [pip_pkg::COORD_BITS-1:0] req_coord_x,
   input  wire logic signed [pip_pkg::COORD_BITS-1:0] req_coord_y,
   input  wire logic                                  rsp_valid,
   input  wire logic                                  rsp_inside_res,
   input  wire logic                                  csr_wr_en,
   input  wire logic [pip_pkg::CFG_BITS-1:0]          csr_wr_data,
   output int                                         fail_count,
   output int                                         pending_answers
);

   import pip_pkg::*;

   logic signed [COORD_BITS-1:0] vert_x [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] vert_y [MAX_VERTICES];
   logic [CFG_BITS-1:0]          poly_count = '0;
   logic                         inside_answers [$];
   int                           mismatches = 0;

   initial begin
      fail_count      = 0;
      pending_answers = 0;
   end

   function automatic logic ray_parity(input logic signed [COORD_BITS-1:0] px,
                                       input logic signed [COORD_BITS-1:0] py);
      int                           n;
      int                           i;
      int                           j;
      logic                         odd;
      logic                         left;
      logic signed [COORD_BITS-1:0] xi;
      logic signed [COORD_BITS-1:0] yi;
      logic signed [COORD_BITS-1:0] xj;
      logic signed [COORD_BITS-1:0] yj;
      logic signed [COORD_BITS:0]   dy;
      logic signed [COORD_BITS:0]   dpx;
      logic signed [COORD_BITS:0]   ex;
      logic signed [COORD_BITS:0]   dpy;
      logic signed [PROD_BITS-1:0]  lhs;
      logic signed [PROD_BITS-1:0]  rhs;
      n = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
      if (n < MIN_POLY_VERTS)
         return 1'b1;
      odd = 1'b0;
      j = n - 1;
      for (i = 0; i < n; i++) begin
         xi = vert_x[i];
         yi = vert_y[i];
         xj = vert_x[j];
         yj = vert_y[j];
         if ((yi > py) != (yj > py)) begin
            dy   = yj - yi;
            dpx  = px - xi;
            ex   = xj - xi;
            dpy  = py - yi;
            lhs  = dpx * dy;
            rhs  = ex * dpy;
            left = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
            if (left)
               odd = ~odd;
         end
         j = i;
      end
      return odd;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatches < 40)
         $display("ERROR at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      logic expected_inside;
      if (reset) begin
         poly_count = '0;
         inside_answers.delete();
      end else begin
         if (rsp_valid) begin
            if (inside_answers.size() == 0) begin
               report_mismatch($sformatf("inside_res=%b with no query waiting",
                                         rsp_inside_res));
            end else begin
               expected_inside = inside_answers.pop_front();
               if (rsp_inside_res !== expected_inside)
                  report_mismatch($sformatf("inside_res=%b, expected %b",
                                            rsp_inside_res, expected_inside));
            end
         end
         if (csr_wr_en)
            poly_count = csr_wr_data;
         if (start && !busy) begin
            if (req_kind == KIND_WRITE) begin
               vert_x[req_vertex_index] = req_coord_x;
               vert_y[req_vertex_index] = req_coord_y;
            end else begin
               inside_answers = {inside_answers, ray_parity(req_coord_x, req_coord_y)};
            end
         end
      end
      fail_count      <= mismatches;
      pending_answers <= inside_answers.size();
   end

endmodule

>>> test/point_in_polygon_test_core_tb.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_core_tb
// Drives vertex writes and point queries into the point-in-polygon core in
// bursts with random gaps. A directed opening covers an empty polygon, too few
// vertices, a square with points on edges and vertices, and a triangle at the
// coordinate extremes; random phases then load polygons of random size and
// spread, set the vertex count (saturating counts included) and query points
// on, near and far from the vertices. A checker beside the core scores it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module point_in_polygon_test_core_tb;

   import pip_pkg::*;

   localparam int ITEM_TARGET  = 1400;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 80;
   localparam int Q16_ONE      = 65536;

   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

   logic                         clock            = 1'b0;
   logic                         reset            = 1'b1;
   logic                         start            = 1'b0;
   logic                         busy;
   logic                         req_kind         = KIND_WRITE;
   logic [IDX_BITS-1:0]          req_vertex_index = '0;
   logic signed [COORD_BITS-1:0] req_coord_x      = '0;
   logic signed [COORD_BITS-1:0] req_coord_y      = '0;
   logic                         rsp_valid;
   logic                         rsp_inside_res;
   logic                         csr_wr_en        = 1'b0;
   logic [CFG_BITS-1:0]          csr_wr_data      = '0;

   int fail_count;
   int pending_answers;
   int cycle_count  = 0;
   int items_sent   = 0;
   int queries_sent = 0;
   int count_writes = 0;
   int burst_left   = 0;

   logic signed [COORD_BITS-1:0] poly_x [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] poly_y [MAX_VERTICES];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   point_in_polygon_test_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_valid        (rsp_valid),
      .rsp_inside_res   (rsp_inside_res),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   point_in_polygon_test_core_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_valid        (rsp_valid),
      .rsp_inside_res   (rsp_inside_res),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .fail_count       (fail_count),
      .pending_answers  (pending_answers)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("point_in_polygon_test_core test failed");
         $finish;
      end
   end

   function automatic logic signed [COORD_BITS-1:0] pick_coord(input int mode);
      case (mode)
         0: return (int'($urandom_range(0, 16)) - 8) * Q16_ONE;
         1: return int'($urandom_range(0, 16 * Q16_ONE)) - 8 * Q16_ONE;
         2: return $urandom;
         default: begin
            case ($urandom_range(0, 4))
               0: return COORD_MIN;
               1: return COORD_MAX;
               2: return 0;
               3: return -1;
               default: return 1;
            endcase
         end
      endcase
   endfunction

   task automatic send_item(input logic                         kind,
                            input int                           idx,
                            input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] y);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      start            <= 1'b1;
      req_kind         <= kind;
      req_vertex_index <= IDX_BITS'(idx);
      req_coord_x      <= x;
      req_coord_y      <= y;
      do @(posedge clock); while (busy);
      burst_left--;
      items_sent++;
      if (kind == KIND_QUERY) begin
         queries_sent++;
      end else begin
         poly_x[idx] = x;
         poly_y[idx] = y;
      end
   endtask

   task automatic set_count(input int value);
      start <= 1'b0;
      do @(posedge clock); while (pending_answers != 0 || busy);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CFG_BITS'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      count_writes++;
      burst_left = 0;
   endtask

   initial begin : stimulus
      int                           n;
      int                           used;
      int                           pmode;
      int                           phase;
      int                           k;
      int                           k1;
      int                           r;
      logic signed [COORD_BITS-1:0] qx;
      logic signed [COORD_BITS-1:0] qy;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty polygon after reset
      send_item(KIND_QUERY, 0, COORD_MIN, COORD_MIN);
      send_item(KIND_QUERY, 63, COORD_MAX, COORD_MAX);

      // square of side 4 m around the origin
      send_item(KIND_WRITE, 0, -2 * Q16_ONE, -2 * Q16_ONE);
      send_item(KIND_WRITE, 1,  2 * Q16_ONE, -2 * Q16_ONE);
      send_item(KIND_WRITE, 2,  2 * Q16_ONE,  2 * Q16_ONE);
      send_item(KIND_WRITE, 3, -2 * Q16_ONE,  2 * Q16_ONE);
      set_count(2);
      send_item(KIND_QUERY, 0, 3 * Q16_ONE, 3 * Q16_ONE);
      set_count(4);
      send_item(KIND_QUERY, 0, 0, 0);
      send_item(KIND_QUERY, 0, 3 * Q16_ONE, 0);
      send_item(KIND_QUERY, 0, -2 * Q16_ONE, 0);
      send_item(KIND_QUERY, 0, 2 * Q16_ONE, 0);
      send_item(KIND_QUERY, 0, -2 * Q16_ONE, -2 * Q16_ONE);
      send_item(KIND_QUERY, 0, 2 * Q16_ONE, 2 * Q16_ONE);
      send_item(KIND_QUERY, 0, COORD_MIN, 0);
      send_item(KIND_QUERY, 0, COORD_MAX, COORD_MAX);

      // triangle spanning the full coordinate range
      send_item(KIND_WRITE, 0, COORD_MIN, COORD_MIN);
      send_item(KIND_WRITE, 1, COORD_MAX, COORD_MIN);
      send_item(KIND_WRITE, 2, 0, COORD_MAX);
      set_count(3);
      send_item(KIND_QUERY, 0, 0, 0);
      send_item(KIND_QUERY, 0, COORD_MIN, COORD_MAX);
      send_item(KIND_QUERY, 0, COORD_MAX, COORD_MAX - 1);
      send_item(KIND_QUERY, 0, -1, -1);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         if (phase == 0) begin
            n = 127;
         end else if (phase == 1) begin
            n = 0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 8)
               n = $urandom_range(0, 2);
            else if (r < 16)
               n = MAX_VERTICES;
            else if (r < 22)
               n = $urandom_range(MAX_VERTICES + 1, 127);
            else
               n = $urandom_range(3, 10);
         end
         used  = (n > MAX_VERTICES) ? MAX_VERTICES : n;
         pmode = ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(0, 2);

         for (k = 0; k < used; k++)
            send_item(KIND_WRITE, k, pick_coord(pmode), pick_coord(pmode));
         set_count(n);

         repeat ($urandom_range(20, 50)) begin
            r  = $urandom_range(0, 19);
            k  = (used > 0) ? $urandom_range(0, used - 1) : 0;
            k1 = (k + 1 < used) ? k + 1 : 0;
            if (r < 3) begin
               send_item(KIND_WRITE, $urandom_range(0, MAX_VERTICES - 1),
                         pick_coord(pmode), pick_coord(pmode));
            end else begin
               qx = pick_coord(pmode);
               qy = pick_coord(pmode);
               if (used > 0) begin
                  case (r)
                     3, 4, 5: begin
                        qx = poly_x[k];
                        qy = poly_y[k];
                     end
                     6, 7: qx = poly_x[k];
                     8, 9: qy = poly_y[k];
                     10, 11: begin
                        qx = (poly_x[k] >>> 1) + (poly_x[k1] >>> 1);
                        qy = (poly_y[k] >>> 1) + (poly_y[k1] >>> 1);
                     end
                     12: qx = $urandom;
                     13: qy = pick_coord(3);
                     default: ;
                  endcase
               end
               send_item(KIND_QUERY, $urandom_range(0, MAX_VERTICES - 1), qx, qy);
            end
         end
         phase++;
      end

      start <= 1'b0;
      do @(posedge clock); while (pending_answers != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items (%0d point queries) across %0d polygon phases", items_sent,
               queries_sent, phase);
      $display("and %0d vertex-count writes, counts from 0 to 127.", count_writes);
      if (fail_count == 0)
         $display("point_in_polygon_test_core test passed");
      else
         $display("point_in_polygon_test_core test failed");
      $finish;
   end

endmodule
